>>> hdl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, geometry constants and helpers of the set-associative cache.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int SETS       = 16;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 32;
  localparam int MEM_BYTES  = 65536;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 32;
  localparam int LINE_WORDS = LINE_BYTES / 4;
  localparam int MEM_WORDS  = MEM_BYTES / 4;
  localparam int LW_W       = $clog2(LINE_WORDS);
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W      = WAY_W;
  localparam int LINES      = SETS * WAYS;
  localparam int LINE_AW    = $clog2(LINES);
  localparam int DATA_DEPTH = LINES * LINE_WORDS;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int CNT_W      = LW_W + 1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam logic POL_WT     = 1'b0;
  localparam logic POL_WB     = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] write_data;
  } sacl_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              wrote_back;
  } sacl_out_t;

  // one set row of the tag store
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][AGE_W-1:0] age;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // write/read request toward one generic RAM
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               we;
    logic [DATA_AW-1:0] waddr;
    logic [DATA_W-1:0]  wdata;
    logic [DATA_AW-1:0] raddr;
  } data_req_t;

  typedef struct packed {
    logic             we;
    logic [SET_W-1:0] waddr;
    meta_t            wdata;
    logic [SET_W-1:0] raddr;
  } meta_req_t;

endpackage

>>> hdl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// Request sequencer: tag lookup, victim choice, write-back, fill, access.
// ----------------------------------------------------------------------------
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sacl_in_t  in_req,
  output logic      out_strobe,
  output sacl_out_t out_res,
  input  logic      policy,
  output meta_req_t meta_req,
  input  meta_t     meta_rd,
  output data_req_t data_req,
  input  logic [DATA_W-1:0] data_rd,
  output mem_req_t  mem_req,
  input  logic [DATA_W-1:0] mem_rd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOOKUP = 7'b0000100,
    ST_EVICT  = 7'b0001000,
    ST_FILL   = 7'b0010000,
    ST_ACCESS = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [MEM_AW-1:0]          clr_r, clr_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SETS-1:0][WAYS-1:0]  valid_r, valid_nxt;
  sacl_in_t                   req_r, req_nxt;
  meta_t                      meta_r, meta_nxt;
  logic [WAY_W-1:0]           way_r, way_nxt;
  logic                       hit_r, hit_nxt;
  logic                       wb_r, wb_nxt;

  logic [SET_W-1:0]   set_s;
  logic [TAG_W-1:0]   tag_s;
  logic [LW_W-1:0]    word_s;
  logic [LINE_AW-1:0] line_s;
  logic [LW_W-1:0]    cnt_lo;
  logic [LW_W-1:0]    cnt_m1;
  logic               cnt_end;
  logic [WAYS-1:0]    vrow;
  logic               lk_hit;
  logic [WAY_W-1:0]   hit_way;
  logic               any_inv;
  logic [WAY_W-1:0]   inv_way;
  logic [WAY_W-1:0]   lru_way;
  logic [AGE_W-1:0]   best;
  logic [WAY_W-1:0]   vic_way;
  meta_t              meta_upd;

  assign set_s   = req_r.addr[OFF_W +: SET_W];
  assign tag_s   = req_r.addr[OFF_W+SET_W +: TAG_W];
  assign word_s  = req_r.addr[2 +: LW_W];
  assign line_s  = LINE_AW'(32'(set_s) * WAYS + 32'(way_r));
  assign cnt_lo  = cnt_r[LW_W-1:0];
  assign cnt_m1  = LW_W'(cnt_r - CNT_W'(1));
  assign cnt_end = (cnt_r == CNT_W'(LINE_WORDS));
  assign vrow    = valid_r[set_s];

  // tag compare, lowest matching way wins
  always_comb begin
    lk_hit  = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && meta_rd.tag[w] == tag_s) begin
        lk_hit  = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // victim: lowest invalid way, else oldest (highest way on a tie)
  always_comb begin
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    best    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (meta_rd.age[w] >= best) begin
        best    = meta_rd.age[w];
        lru_way = WAY_W'(w);
      end
    end
    vic_way = any_inv ? inv_way : lru_way;
  end

  // updated set row: age touch, tag, dirty
  always_comb begin
    meta_upd = meta_r;
    for (int v = 0; v < WAYS; v++) begin
      if (WAY_W'(v) != way_r && vrow[v] &&
          (!vrow[way_r] || meta_r.age[v] < meta_r.age[way_r])) begin
        meta_upd.age[v] = meta_r.age[v] + AGE_W'(1);
      end
    end
    meta_upd.age[way_r] = '0;
    meta_upd.tag[way_r] = tag_s;
    if (!hit_r) begin
      meta_upd.dirty[way_r] = 1'b0;
    end
    if (req_r.func == FUNC_WRITE && policy == POL_WB) begin
      meta_upd.dirty[way_r] = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    req_nxt   = req_r;
    meta_nxt  = meta_r;
    way_nxt   = way_r;
    hit_nxt   = hit_r;
    wb_nxt    = wb_r;
    meta_req  = '0;
    data_req  = '0;
    mem_req   = '0;
    meta_req.raddr = in_req.addr[OFF_W +: SET_W];
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        clr_nxt       = clr_r + MEM_AW'(1);
        if (clr_r == MEM_AW'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        meta_nxt = meta_rd;
        hit_nxt  = lk_hit;
        cnt_nxt  = '0;
        if (lk_hit) begin
          way_nxt   = hit_way;
          wb_nxt    = 1'b0;
          state_nxt = ST_ACCESS;
        end else begin
          way_nxt   = vic_way;
          wb_nxt    = vrow[vic_way] && meta_rd.dirty[vic_way] && policy == POL_WB;
          state_nxt = (vrow[vic_way] && meta_rd.dirty[vic_way] && policy == POL_WB)
                      ? ST_EVICT : ST_FILL;
        end
      end
      ST_EVICT: begin
        // read line word k, write word k-1 to memory
        data_req.raddr = {line_s, cnt_lo};
        if (cnt_r != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = MEM_AW'({meta_r.tag[way_r], set_s, cnt_m1});
          mem_req.wdata = data_rd;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        // read memory word k, write line word k-1
        mem_req.raddr = MEM_AW'({tag_s, set_s, cnt_lo});
        if (cnt_r != '0) begin
          data_req.we    = 1'b1;
          data_req.waddr = {line_s, cnt_m1};
          data_req.wdata = mem_rd;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_end) begin
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        data_req.raddr = {line_s, word_s};
        if (req_r.func == FUNC_WRITE) begin
          data_req.we    = 1'b1;
          data_req.waddr = {line_s, word_s};
          data_req.wdata = req_r.write_data;
          if (policy == POL_WT) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = MEM_AW'(32'(req_r.addr[ADDR_W-1:2]));
            mem_req.wdata = req_r.write_data;
          end
        end
        meta_req.we    = 1'b1;
        meta_req.waddr = set_s;
        meta_req.wdata = meta_upd;
        valid_nxt[set_s][way_r] = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    meta_r <= meta_nxt;
    way_r  <= way_nxt;
    hit_r  <= hit_nxt;
    wb_r   <= wb_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_strobe         = (state_r == ST_RESP);
  assign out_res.read_data  = (req_r.func == FUNC_WRITE) ? '0 : data_rd;
  assign out_res.hit        = hit_r;
  assign out_res.wrote_back = wb_r;

endmodule

>>> hdl/set_assoc_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_unit
// Set-associative LRU cache with built-in main memory.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a word request on in_req; it transfers at a clock edge
//   where busy is low. One result per request appears on out_res for exactly
//   one cycle with out_strobe high; the receiver cannot stall it.
//   cfg_we/cfg_wdata write the write policy (0 write-through, 1 write-back);
//   write it only while busy is low.
// Sequence (transfer edge to strobe cycle):
//   hit                     : lookup, access, response
//   miss, clean victim      : lookup, line fill, access, response
//   miss, dirty write-back  : lookup, write-back, line fill, access, response
//   Busy drops the cycle after the strobe. The line store and main memory
//   move one word per cycle, which sets the miss cost.
// Reset:
//   All lines become invalid and main memory is swept to zero, one word a
//   cycle; busy stays high until all MEM_WORDS (16384) words are cleared.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_unit
  import sacl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sacl_in_t  in_req,
  output logic      out_strobe,
  output sacl_out_t out_res,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic              policy_r;
  meta_req_t         meta_req;
  meta_t             meta_rd;
  data_req_t         data_req;
  logic [DATA_W-1:0] data_rd;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rd;

  // hold write policy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_WT;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  sacl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .policy     (policy_r),
    .meta_req   (meta_req),
    .meta_rd    (meta_rd),
    .data_req   (data_req),
    .data_rd    (data_rd),
    .mem_req    (mem_req),
    .mem_rd     (mem_rd)
  );

  sacl_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_req.we),
    .waddr (meta_req.waddr),
    .wdata (meta_req.wdata),
    .raddr (meta_req.raddr),
    .rdata (meta_rd)
  );

  sacl_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_req.we),
    .waddr (data_req.waddr),
    .wdata (data_req.wdata),
    .raddr (data_req.raddr),
    .rdata (data_rd)
  );

  sacl_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rd)
  );

endmodule

>>> bench/tb_set_assoc_lru_cache_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_unit
// Self-checking bench for the set-associative LRU cache: a behavioral copy of
// tags, age ranks, line words and main memory predicts every result, which a
// scoreboard compares with the strobed output. Runs under both write policies.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_unit;
  import sacl_pkg::*;

  class cache_scoreboard;
    logic             policy;
    logic [TAG_W-1:0] tags   [LINES];
    logic             valid  [LINES];
    logic             dirty  [LINES];
    int unsigned      rank   [LINES];
    logic [31:0]      words  [LINES*LINE_WORDS];
    logic [31:0]      memory [MEM_WORDS];
    sacl_out_t        pending[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      hits;
    int unsigned      writebacks;

    function new();
      policy = POL_WT;
      errors = 0; checked = 0; hits = 0; writebacks = 0;
      foreach (valid[i]) begin
        valid[i] = 0; dirty[i] = 0; rank[i] = 0; tags[i] = '0;
      end
      foreach (words[i]) words[i] = '0;
      foreach (memory[i]) memory[i] = '0;
    endfunction

    // Make way w the most recent of its set.
    function void promote(int base, int w);
      int unsigned old;
      old = valid[base+w] ? rank[base+w] : WAYS;
      for (int v = 0; v < WAYS; v++)
        if (v != w && valid[base+v] && rank[base+v] < old) rank[base+v]++;
      rank[base+w] = 0;
    endfunction

    // Predict the result of one accepted request.
    function void note_request(sacl_in_t r);
      int unsigned blk, set_i, tg, wil, base, way, ln, best, vblk, fw;
      sacl_out_t res;
      blk = r.addr[15:2] / LINE_WORDS;
      set_i = blk % SETS; tg = blk / SETS; wil = r.addr[15:2] % LINE_WORDS;
      base = set_i * WAYS; way = WAYS;
      res = '0;
      for (int w = 0; w < WAYS; w++)
        if (way == WAYS && valid[base+w] && tags[base+w] == tg) way = w;
      if (way != WAYS) begin
        res.hit = 1; promote(base, way);
      end else begin
        for (int w = 0; w < WAYS; w++)
          if (way == WAYS && !valid[base+w]) way = w;
        if (way == WAYS) begin
          best = 0; way = 0;
          for (int w = 0; w < WAYS; w++)
            if (rank[base+w] >= best) begin best = rank[base+w]; way = w; end
        end
        ln = base + way;
        if (valid[ln] && dirty[ln] && policy == POL_WB) begin
          vblk = tags[ln] * SETS + set_i;
          for (int k = 0; k < LINE_WORDS; k++)
            memory[(vblk*LINE_WORDS + k) % MEM_WORDS] = words[ln*LINE_WORDS + k];
          res.wrote_back = 1;
        end
        fw = blk * LINE_WORDS;
        for (int k = 0; k < LINE_WORDS; k++)
          words[ln*LINE_WORDS + k] = memory[(fw + k) % MEM_WORDS];
        promote(base, way);
        valid[ln] = 1; tags[ln] = TAG_W'(tg); dirty[ln] = 0;
      end
      ln = base + way;
      if (r.func == FUNC_READ) res.read_data = words[ln*LINE_WORDS + wil];
      else begin
        words[ln*LINE_WORDS + wil] = r.write_data;
        if (policy == POL_WT) memory[r.addr[15:2]] = r.write_data;
        else dirty[ln] = 1;
      end
      pending.push_back(res);
    endfunction

    function void check_result(sacl_out_t got);
      sacl_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, got); return;
      end
      want = pending.pop_front();
      checked++;
      if (got.hit) hits++;
      if (got.wrote_back) writebacks++;
      if (got.read_data !== want.read_data) report_mismatch("read_data", want, got);
      if (got.hit !== want.hit) report_mismatch("hit", want, got);
      if (got.wrote_back !== want.wrote_back) report_mismatch("wrote_back", want, got);
    endfunction

    function void report_mismatch(string what, sacl_out_t want, sacl_out_t got);
      errors++;
      $display("MISMATCH %s at %0t: want %h got %h", what, $realtime, want, got);
    endfunction
  endclass

  logic      clk, rst_n, start, busy, out_strobe, cfg_we, cfg_wdata;
  sacl_in_t  in_req;
  sacl_out_t out_res;
  cache_scoreboard sb;
  int unsigned idle_pct;
  longint unsigned cycles = 0;

  set_assoc_lru_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Check every strobed result; stop on runaway.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) sb.check_result(out_res);
    if (cycles > 4000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Transfer one request, with optional idle cycles ahead of it.
  task automatic send_request(logic f, logic [15:0] a, logic [31:0] d);
    sacl_in_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    r.func = f; r.addr = a; r.write_data = d;
    start <= 1; in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  // Drain all expected results, then write the policy register.
  task automatic set_policy(logic p);
    start <= 0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 0;
    sb.policy = p;
  endtask

  // Mostly addresses from a few sets to force conflicts and evictions.
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(99) < 80) begin
      a[8:5] = 4'($urandom_range(2));
      a[15:9] = 7'($urandom_range(6));
    end
    return a;
  endfunction

  initial begin
    logic [31:0] d;
    sb = new();
    rst_n = 0; start = 0; cfg_we = 0; cfg_wdata = 0; in_req = '0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    set_policy(POL_WT);
    // Directed: extremes, unaligned bits, conflict set, policy switch over dirty.
    send_request(FUNC_READ, 16'h0000, 32'hFFFF_FFFF);
    send_request(FUNC_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_READ, 16'hFFFC, 32'h0);
    send_request(FUNC_WRITE, 16'h0003, 32'h0);
    send_request(FUNC_WRITE, 16'h0004, 32'hA5A5_5A5A);
    for (int t = 0; t < 6; t++) send_request(FUNC_READ, 16'(t << 9), 32'h0);
    set_policy(POL_WB);
    for (int t = 0; t < 6; t++) send_request(FUNC_WRITE, 16'((t << 9) | 8), 32'(t + 1));
    for (int t = 0; t < 6; t++) send_request(FUNC_READ, 16'((t << 9) | 8), 32'h0);
    set_policy(POL_WT);
    for (int t = 6; t < 11; t++) send_request(FUNC_READ, 16'(t << 9), 32'h0);
    // Random phases with changing policy and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      set_policy(ph[0]);
      idle_pct = (ph < 2) ? 8 : (ph < 4) ? 57 : 0;
      for (int i = 0; i < 140; i++) begin
        d = $urandom;
        send_request(1'($urandom), pick_addr(), d);
      end
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d results under both write policies: %0d hits, %0d write-backs.",
             sb.checked, sb.hits, sb.writebacks);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/sacl_pkg.sv
hdl/sacl_ram.sv
hdl/sacl_ctrl.sv
hdl/set_assoc_lru_cache_unit.sv
bench/tb_set_assoc_lru_cache_unit.sv
